/* rtl/core/rbd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared constants, types and helper functions for the raw bit depth detector.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int unsigned FRAME_BYTES_W = 27;
  localparam int unsigned WORD_W        = 16;
  localparam int unsigned INDEX_W       = 17;
  localparam int unsigned COUNT_W       = 14;
  localparam int unsigned DEPTH_W       = 5;
  localparam int unsigned PATH_W        = 3;
  localparam int unsigned SIZE_W        = 25;

  localparam logic [INDEX_W-1:0] WIDE_WINDOW   = 17'd100000;
  localparam logic [INDEX_W-1:0] NARROW_WINDOW = 17'd10000;
  localparam logic [INDEX_W-1:0] INDEX_MAX     = '1;

  localparam logic [DEPTH_W-1:0] DEPTH_NONE = 5'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_8    = 5'd8;
  localparam logic [DEPTH_W-1:0] DEPTH_10   = 5'd10;
  localparam logic [DEPTH_W-1:0] DEPTH_12   = 5'd12;
  localparam logic [DEPTH_W-1:0] DEPTH_14   = 5'd14;
  localparam logic [DEPTH_W-1:0] DEPTH_16   = 5'd16;

  localparam logic [PATH_W-1:0] PATH_EMPTY    = 3'd0;
  localparam logic [PATH_W-1:0] PATH_BYTES    = 3'd1;
  localparam logic [PATH_W-1:0] PATH_HALF     = 3'd2;
  localparam logic [PATH_W-1:0] PATH_PACKED   = 3'd3;
  localparam logic [PATH_W-1:0] PATH_FALLBACK = 3'd4;

  localparam int unsigned NUM_SIZES = 22;

  localparam logic [SIZE_W-1:0] KNOWN_SIZES [NUM_SIZES] = '{
    25'(640*480),   25'(720*480),   25'(720*576),   25'(800*600),
    25'(1024*768),  25'(1280*720),  25'(1280*800),  25'(1280*1024),
    25'(1440*900),  25'(1920*1080), 25'(1920*1200), 25'(2048*1536),
    25'(2560*1440), 25'(2560*1600), 25'(3840*2160), 25'(4096*2160),
    25'(4096*3072), 25'(5120*2880), 25'(5320*4600), 25'(7680*4320),
    25'(1006*758),  25'(4024*3032)
  };

  // per-frame values that follow from frame_bytes alone
  typedef struct packed {
    logic                 empty;
    logic                 known_full;
    logic                 known_half;
    logic                 size_ge8;
    logic [DEPTH_W-1:0]   packed_depth;
    logic                 even_ge4;
    logic [COUNT_W-1:0]   sample_size;
    logic [19:0]          sample_x85;
    logic [14:0]          sample_x3;
  } cfg_flags_t;

  function automatic logic is_known(input logic [FRAME_BYTES_W-1:0] n);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_SIZES; i++) begin
      if (n == {2'b00, KNOWN_SIZES[i]}) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // floor(bits/d) or floor(bits/d)+1 is a known size: bits in [(k-1)*d, k*d+d-1]
  function automatic logic packed_match(input logic [FRAME_BYTES_W-1:0] fb,
                                        input logic [DEPTH_W-1:0] d);
    logic [31:0] bits;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] dw;
    logic        hit;
    bits = {2'b00, fb, 3'b000};
    dw   = {27'b0, d};
    hit  = 1'b0;
    for (int i = 0; i < NUM_SIZES; i++) begin
      lo = ({7'b0, KNOWN_SIZES[i]} - 32'd1) * dw;
      hi = {7'b0, KNOWN_SIZES[i]} * dw + dw - 32'd1;
      if (bits >= lo && bits <= hi) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/rbd_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_cfg_regs
// Frame size register and the registered size checks derived from it.
// ----------------------------------------------------------------------------
module rbd_cfg_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 frame_bytes_wr_en,
  input  wire logic [rbd_pkg::FRAME_BYTES_W-1:0]    frame_bytes_wr_data,
  output logic      [rbd_pkg::FRAME_BYTES_W-1:0]    frame_bytes,
  output rbd_pkg::cfg_flags_t                       flags
);

  rbd_pkg::cfg_flags_t             flags_next;
  logic [rbd_pkg::FRAME_BYTES_W-2:0] half;
  logic [rbd_pkg::COUNT_W-1:0]     sample_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bytes <= '0;
    end else if (frame_bytes_wr_en) begin
      frame_bytes <= frame_bytes_wr_data;
    end
  end

  assign half = frame_bytes[rbd_pkg::FRAME_BYTES_W-1:1];

  always_comb begin
    if (half < 26'(rbd_pkg::NARROW_WINDOW)) begin
      sample_size = half[rbd_pkg::COUNT_W-1:0];
    end else begin
      sample_size = rbd_pkg::NARROW_WINDOW[rbd_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    flags_next.empty       = (frame_bytes == '0);
    flags_next.known_full  = rbd_pkg::is_known(frame_bytes);
    flags_next.known_half  = !frame_bytes[0] && rbd_pkg::is_known({1'b0, half});
    flags_next.size_ge8    = (frame_bytes >= 27'd8);
    flags_next.even_ge4    = !frame_bytes[0] && (frame_bytes >= 27'd4);
    flags_next.sample_size = sample_size;
    flags_next.sample_x85  = 20'(sample_size) * 20'd85;
    flags_next.sample_x3   = 15'(sample_size) * 15'd3;
    priority if (rbd_pkg::packed_match(frame_bytes, rbd_pkg::DEPTH_10)) begin
      flags_next.packed_depth = rbd_pkg::DEPTH_10;
    end else if (rbd_pkg::packed_match(frame_bytes, rbd_pkg::DEPTH_12)) begin
      flags_next.packed_depth = rbd_pkg::DEPTH_12;
    end else if (rbd_pkg::packed_match(frame_bytes, rbd_pkg::DEPTH_14)) begin
      flags_next.packed_depth = rbd_pkg::DEPTH_14;
    end else if (rbd_pkg::packed_match(frame_bytes, rbd_pkg::DEPTH_16)) begin
      flags_next.packed_depth = rbd_pkg::DEPTH_16;
    end else begin
      flags_next.packed_depth = rbd_pkg::DEPTH_NONE;
    end
  end

  // flags follow frame_bytes in the next cycle; requests do not wait for them
  always_ff @(posedge clk) begin
    flags <= flags_next;
  end

endmodule
`default_nettype wire

/* rtl/core/raw_bit_depth_detector.sv */
// Result path: a request marked last first sits in the input register, then the
//   statistics update and decision load the result register.
// Throughput: one request per cycle; only a last request can be held back, while
//   a previous result is still waiting to be taken.
// Reset: synchronous, clears frame_bytes, all statistics and both valid flags.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// raw_bit_depth_detector
// Gathers running statistics over a raw frame's words and decides its depth.
// ----------------------------------------------------------------------------
module raw_bit_depth_detector (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              frame_bytes_wr_en,
  input  wire logic [rbd_pkg::FRAME_BYTES_W-1:0] frame_bytes_wr_data,
  input  wire logic                              sample_valid,
  output logic                                   sample_stall,
  input  wire logic [rbd_pkg::WORD_W-1:0]        sample_word,
  input  wire logic                              is_last,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output logic      [rbd_pkg::DEPTH_W-1:0]       pixel_depth,
  output logic      [rbd_pkg::PATH_W-1:0]        decision_path
);

  logic [rbd_pkg::FRAME_BYTES_W-1:0] frame_bytes;
  rbd_pkg::cfg_flags_t               flags;

  logic                          word_valid;
  logic [rbd_pkg::WORD_W-1:0]    word;
  logic                          word_last;
  logic                          fire;

  logic [rbd_pkg::INDEX_W-1:0]   word_index;
  logic [rbd_pkg::WORD_W-1:0]    max_wide_window;
  logic [rbd_pkg::WORD_W-1:0]    max_narrow_window;
  logic [rbd_pkg::COUNT_W-1:0]   upper_byte_count;
  logic [rbd_pkg::COUNT_W-1:0]   zero_word_count;

  logic [rbd_pkg::INDEX_W-1:0]   word_index_next;
  logic [rbd_pkg::WORD_W-1:0]    max_wide_next;
  logic [rbd_pkg::WORD_W-1:0]    max_narrow_next;
  logic [rbd_pkg::COUNT_W-1:0]   high_byte_next;
  logic [rbd_pkg::COUNT_W-1:0]   zero_word_next;

  logic                          in_frame;
  logic [20:0]                   high_x100;
  logic [20:0]                   zero_x100;
  logic [17:0]                   high_x10;
  logic                          looks_packed;
  logic [rbd_pkg::DEPTH_W-1:0]   depth_next;
  logic [rbd_pkg::PATH_W-1:0]    path_next;

  rbd_cfg_regs u_cfg (
    .clk                 (clk),
    .rst                 (rst),
    .frame_bytes_wr_en   (frame_bytes_wr_en),
    .frame_bytes_wr_data (frame_bytes_wr_data),
    .frame_bytes         (frame_bytes),
    .flags               (flags)
  );

  // only a last word waits, and only on a held result
  assign fire         = word_valid && (!word_last || !result_valid || !result_stall);
  assign sample_stall = word_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (!sample_stall) begin
      word_valid <= sample_valid;
    end
    if (!sample_stall) begin
      word      <= sample_word;
      word_last <= is_last;
    end
  end

  // statistics including the current word
  always_comb begin
    in_frame        = {9'b0, word_index} < frame_bytes[rbd_pkg::FRAME_BYTES_W-1:1];
    max_wide_next   = max_wide_window;
    max_narrow_next = max_narrow_window;
    high_byte_next  = upper_byte_count;
    zero_word_next  = zero_word_count;
    if (in_frame) begin
      if (word_index < rbd_pkg::WIDE_WINDOW && word > max_wide_window) begin
        max_wide_next = word;
      end
      if (word_index < rbd_pkg::NARROW_WINDOW) begin
        if (word > max_narrow_window) begin
          max_narrow_next = word;
        end
        if (word[15:8] != 8'd0) begin
          high_byte_next = upper_byte_count + 14'd1;
        end
        if (word == '0) begin
          zero_word_next = zero_word_count + 14'd1;
        end
      end
    end
    if (word_index != rbd_pkg::INDEX_MAX) begin
      word_index_next = word_index + 17'd1;
    end else begin
      word_index_next = word_index;
    end
  end

  always_comb begin
    high_x100    = 21'(high_byte_next) * 21'd100;
    zero_x100    = 21'(zero_word_next) * 21'd100;
    high_x10     = 18'(high_byte_next) * 18'd10;
    looks_packed = flags.size_ge8 && (high_x100 > {1'b0, flags.sample_x85}) &&
                   (zero_x100 < {7'b0, flags.sample_size});
    depth_next   = rbd_pkg::DEPTH_8;
    path_next    = rbd_pkg::PATH_FALLBACK;
    priority if (flags.empty) begin
      depth_next = rbd_pkg::DEPTH_NONE;
      path_next  = rbd_pkg::PATH_EMPTY;
    end else if (flags.known_full) begin
      depth_next = rbd_pkg::DEPTH_8;
      path_next  = rbd_pkg::PATH_BYTES;
    end else if (flags.known_half) begin
      path_next = rbd_pkg::PATH_HALF;
      priority if (max_wide_next <= 16'd255) begin
        depth_next = rbd_pkg::DEPTH_8;
      end else if (max_wide_next <= 16'd1023) begin
        depth_next = rbd_pkg::DEPTH_10;
      end else if (max_wide_next <= 16'd4095) begin
        depth_next = rbd_pkg::DEPTH_12;
      end else if (max_wide_next <= 16'd16383) begin
        depth_next = rbd_pkg::DEPTH_14;
      end else begin
        depth_next = rbd_pkg::DEPTH_16;
      end
    end else if (looks_packed && flags.packed_depth != rbd_pkg::DEPTH_NONE) begin
      depth_next = flags.packed_depth;
      path_next  = rbd_pkg::PATH_PACKED;
    end else if (flags.even_ge4 && (high_x10 > {3'b0, flags.sample_x3}) &&
                 max_narrow_next > 16'd255) begin
      depth_next = rbd_pkg::DEPTH_16;
    end else begin
      depth_next = rbd_pkg::DEPTH_8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index        <= '0;
      max_wide_window   <= '0;
      max_narrow_window <= '0;
      upper_byte_count  <= '0;
      zero_word_count   <= '0;
      result_valid      <= 1'b0;
    end else begin
      if (fire) begin
        if (word_last) begin
          word_index        <= '0;
          max_wide_window   <= '0;
          max_narrow_window <= '0;
          upper_byte_count  <= '0;
          zero_word_count   <= '0;
        end else begin
          word_index        <= word_index_next;
          max_wide_window   <= max_wide_next;
          max_narrow_window <= max_narrow_next;
          upper_byte_count  <= high_byte_next;
          zero_word_count   <= zero_word_next;
        end
      end
      if (fire && word_last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && word_last) begin
      pixel_depth   <= depth_next;
      decision_path <= path_next;
    end
  end

  // the input side is only held by a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (result_valid && result_stall && word_last))
    else $error("input stalled without a held result");

  // a decision starts a new frame
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (fire && word_last) |=> (word_index == '0 && upper_byte_count == '0))
    else $error("statistics not cleared after decision");

  // narrow window is contained in the wide one
  a_max_order: assert property (@(posedge clk) disable iff (rst)
    max_narrow_window <= max_wide_window)
    else $error("narrow maximum exceeds wide maximum");

  // high-byte and zero words are disjoint and each was a counted word
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ({3'b0, upper_byte_count} + {3'b0, zero_word_count}) <= word_index)
    else $error("word counts exceed word index");

  a_path_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (decision_path <= rbd_pkg::PATH_FALLBACK))
    else $error("decision path out of range");

endmodule
`default_nettype wire
